// ===== rtl/core/ucws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucws_pkg
// Shared types, constants and character classification helpers for the
// UTF-8 word splitter.
// ----------------------------------------------------------------------------
package ucws_pkg;

  localparam int WORD_BYTE_CAP = 255;
  localparam int CFG_DATA_W    = 16;
  localparam int EVQ_DEPTH     = 4;
  localparam int EVQ_AW        = $clog2(EVQ_DEPTH);
  localparam int OUTQ_DEPTH    = 2;
  localparam int OUTQ_AW       = $clog2(OUTQ_DEPTH);

  localparam logic CFG_CJK_MODE  = 1'b0;
  localparam logic CFG_MAX_WORDS = 1'b1;

  typedef enum logic [1:0] {
    CLS_SEP,
    CLS_KEPT,
    CLS_CJK
  } chr_cls_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        word_last;
    logic [15:0] word_index;
    logic        text_done;
  } out_item_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    chr_cls_t        cls;
    logic            has_char;
    logic            is_end;
  } char_ev_t;

  function automatic logic cp_is_cjk(input logic [20:0] cp);
    return (cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h03400 && cp <= 21'h04DBF)
        || (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h0F900 && cp <= 21'h0FAFF);
  endfunction

  function automatic logic byte_is_kept(input logic [7:0] c);
    return c == 8'h27 || (c >= 8'h41 && c <= 8'h5A)
        || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ucws_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucws_front
// UTF-8 decoder: collects multi-byte sequences, checks them and classifies
// each finished character as part of a word, an ideograph or a separator.
// ----------------------------------------------------------------------------
module ucws_front (
  input  logic                clk,
  input  logic                rst_n,
  input  ucws_pkg::in_item_t  in_item,
  input  logic                in_acc,
  output logic                ev_push,
  output ucws_pkg::char_ev_t  ev_data
);
  import ucws_pkg::*;

  logic [2:0]      need_r, need_nxt;
  logic [1:0]      have_r, have_nxt;
  logic [2:0][7:0] dec_r, dec_nxt;

  logic [7:0]  c;
  logic [2:0]  lead_len;
  logic [20:0] cp;
  logic        cp_ok;

  assign c = in_item.text_byte;

  always_comb begin
    if (c[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = 3'd0;
    end
  end

  always_comb begin
    unique case (need_r)
      3'd2: begin
        cp    = {10'd0, dec_r[0][4:0], c[5:0]};
        cp_ok = cp >= 21'h80;
      end
      3'd3: begin
        cp    = {5'd0, dec_r[0][3:0], dec_r[1][5:0], c[5:0]};
        cp_ok = cp >= 21'h800;
      end
      default: begin
        cp    = {dec_r[0][2:0], dec_r[1][5:0], dec_r[2][5:0], c[5:0]};
        cp_ok = cp >= 21'h10000;
      end
    endcase
  end

  always_comb begin
    need_nxt         = need_r;
    have_nxt         = have_r;
    dec_nxt          = dec_r;
    ev_data          = '0;
    ev_data.len      = 3'd1;
    ev_data.cls      = CLS_SEP;
    ev_data.is_end   = in_item.end_of_text;
    if (in_item.has_byte) begin
      if (need_r == 3'd0) begin
        if (!c[7]) begin
          ev_data.has_char = 1'b1;
          ev_data.bytes[0] = c;
          ev_data.cls      = byte_is_kept(c) ? CLS_KEPT : CLS_SEP;
        end else if (lead_len == 3'd0) begin
          ev_data.has_char = 1'b1;
          ev_data.bytes[0] = c;
        end else begin
          need_nxt   = lead_len;
          dec_nxt[0] = c;
          have_nxt   = 2'd1;
        end
      end else if (({1'b0, have_r} + 3'd1) < need_r) begin
        dec_nxt[have_r] = c;
        have_nxt        = have_r + 2'd1;
      end else begin
        ev_data.has_char = 1'b1;
        ev_data.len      = need_r;
        ev_data.bytes[0] = dec_r[0];
        ev_data.bytes[1] = (need_r == 3'd2) ? c : dec_r[1];
        ev_data.bytes[2] = (need_r == 3'd3) ? c : dec_r[2];
        ev_data.bytes[3] = (need_r == 3'd4) ? c : 8'd0;
        ev_data.cls      = (cp_ok && cp_is_cjk(cp)) ? CLS_CJK : CLS_SEP;
        need_nxt         = 3'd0;
        have_nxt         = 2'd0;
      end
    end
    if (in_item.end_of_text) begin
      need_nxt = 3'd0;
      have_nxt = 2'd0;
    end
  end

  assign ev_push = in_acc && (ev_data.has_char || ev_data.is_end);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 3'd0;
      have_r <= 2'd0;
    end else if (in_acc) begin
      need_r <= need_nxt;
      have_r <= have_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      dec_r <= dec_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ucws_evq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucws_evq
// Short character queue that decouples the decoder from the word sequencer.
// ----------------------------------------------------------------------------
module ucws_evq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ucws_pkg::char_ev_t  push_data,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output ucws_pkg::char_ev_t  head
);
  import ucws_pkg::*;

  char_ev_t          mem_r [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wptr_r, rptr_r;
  logic [EVQ_AW:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = cnt_r == (EVQ_AW + 1)'(EVQ_DEPTH);
  assign empty   = cnt_r == '0;
  assign head    = mem_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ucws_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ucws_back
// Word sequencer: keeps the open word, applies the byte cap and word limit,
// emits word bytes one per cycle into a two-entry result queue while it has room.
// ----------------------------------------------------------------------------
module ucws_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cjk_mode,
  input  logic [15:0]          word_limit,
  input  logic                 ev_empty,
  input  ucws_pkg::char_ev_t   ev_head,
  output logic                 ev_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output ucws_pkg::out_item_t  out_item
);
  import ucws_pkg::*;

  localparam logic [2:0] ST_DECIDE = 3'd0;
  localparam logic [2:0] ST_CLOSE  = 3'd1;
  localparam logic [2:0] ST_HELD   = 3'd2;
  localparam logic [2:0] ST_CJK    = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  localparam logic [1:0] AFT_FIN  = 2'd0;
  localparam logic [1:0] AFT_CJK  = 2'd1;
  localparam logic [1:0] AFT_HELD = 2'd2;
  localparam logic [1:0] AFT_DONE = 2'd3;

  logic [2:0]      state_r, state_nxt;
  logic [1:0]      after_r, after_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic [3:0][7:0] held_r, held_nxt;
  logic [2:0]      held_len_r, held_len_nxt;
  logic [7:0]      open_r, open_nxt;
  logic [15:0]     words_r, words_nxt;

  out_item_t          oq_mem_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] oq_wptr_r, oq_rptr_r;
  logic [OUTQ_AW:0]   oq_cnt_r;
  logic               oq_full, oq_pop;
  logic               push;
  out_item_t          push_item;

  logic       can, inc_ok, close_emits, held_last, ev_last, finish, close_done, held_done;
  logic [8:0] cap_sum;

  assign can         = words_r < word_limit;
  assign inc_ok      = can && (words_r != 16'hFFFF);
  assign close_emits = (open_r != 8'd0) && (held_len_r != 3'd0);
  assign held_last   = {1'b0, idx_r} == (held_len_r - 3'd1);
  assign ev_last     = {1'b0, idx_r} == (ev_head.len - 3'd1);
  assign cap_sum     = {1'b0, open_r} + {6'd0, ev_head.len};

  always_comb begin
    state_nxt    = state_r;
    after_nxt    = after_r;
    idx_nxt      = idx_r;
    held_nxt     = held_r;
    held_len_nxt = held_len_r;
    open_nxt     = open_r;
    words_nxt    = words_r;
    ev_pop       = 1'b0;
    push         = 1'b0;
    push_item    = '0;
    finish       = 1'b0;
    close_done   = 1'b0;
    held_done    = 1'b0;
    unique case (state_r)
      ST_DECIDE: begin
        if (!ev_empty) begin
          idx_nxt = 2'd0;
          if (!ev_head.has_char) begin
            finish = 1'b1;
          end else begin
            unique case (ev_head.cls)
              CLS_CJK: begin
                state_nxt = ST_CLOSE;
                after_nxt = AFT_CJK;
              end
              CLS_KEPT: begin
                if (cjk_mode && cap_sum >= 9'(WORD_BYTE_CAP)) begin
                  finish = 1'b1;
                end else if (!cjk_mode && open_r >= 8'(WORD_BYTE_CAP)) begin
                  state_nxt = ST_CLOSE;
                  after_nxt = AFT_HELD;
                end else begin
                  state_nxt = ST_HELD;
                end
              end
              default: begin
                state_nxt = ST_CLOSE;
                after_nxt = AFT_FIN;
              end
            endcase
          end
        end
      end
      ST_CLOSE: begin
        if (close_emits) begin
          if (!(can && oq_full)) begin
            push                 = can;
            push_item.data_byte  = held_r[idx_r];
            push_item.word_last  = held_last;
            push_item.word_index = words_r;
            if (held_last) begin
              close_done = 1'b1;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end else begin
          close_done = 1'b1;
        end
        if (close_done) begin
          if (close_emits && inc_ok) begin
            words_nxt = words_r + 16'd1;
          end
          open_nxt     = 8'd0;
          held_len_nxt = 3'd0;
          idx_nxt      = 2'd0;
          unique case (after_r)
            AFT_CJK:  state_nxt = ST_CJK;
            AFT_HELD: state_nxt = ST_HELD;
            AFT_DONE: state_nxt = ST_DONE;
            default:  finish = 1'b1;
          endcase
        end
      end
      ST_HELD: begin
        if (held_len_r == 3'd0) begin
          held_done = 1'b1;
        end else if (!(can && oq_full)) begin
          push                 = can;
          push_item.data_byte  = held_r[idx_r];
          push_item.word_index = words_r;
          if (held_last) begin
            held_done = 1'b1;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        if (held_done) begin
          held_nxt     = ev_head.bytes;
          held_len_nxt = ev_head.len;
          open_nxt     = open_r + 8'(ev_head.len);
          idx_nxt      = 2'd0;
          finish       = 1'b1;
        end
      end
      ST_CJK: begin
        if (!(can && oq_full)) begin
          push                 = can;
          push_item.data_byte  = ev_head.bytes[idx_r];
          push_item.word_last  = ev_last;
          push_item.word_index = words_r;
          if (ev_last) begin
            if (inc_ok) begin
              words_nxt = words_r + 16'd1;
            end
            idx_nxt = 2'd0;
            finish  = 1'b1;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
      end
      ST_DONE: begin
        if (!oq_full) begin
          push                 = 1'b1;
          push_item.word_index = words_r;
          push_item.text_done  = 1'b1;
          words_nxt            = 16'd0;
          held_len_nxt         = 3'd0;
          open_nxt             = 8'd0;
          ev_pop               = 1'b1;
          state_nxt            = ST_DECIDE;
        end
      end
      default: begin
        state_nxt = ST_DECIDE;
      end
    endcase
    if (finish) begin
      if (ev_head.is_end) begin
        state_nxt = ST_CLOSE;
        after_nxt = AFT_DONE;
        idx_nxt   = 2'd0;
      end else begin
        ev_pop    = 1'b1;
        state_nxt = ST_DECIDE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_DECIDE;
      after_r    <= AFT_FIN;
      idx_r      <= 2'd0;
      held_len_r <= 3'd0;
      open_r     <= 8'd0;
      words_r    <= 16'd0;
    end else begin
      state_r    <= state_nxt;
      after_r    <= after_nxt;
      idx_r      <= idx_nxt;
      held_len_r <= held_len_nxt;
      open_r     <= open_nxt;
      words_r    <= words_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

  assign oq_full   = oq_cnt_r == (OUTQ_AW + 1)'(OUTQ_DEPTH);
  assign out_empty = oq_cnt_r == '0;
  assign out_item  = oq_mem_r[oq_rptr_r];
  assign oq_pop    = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      if (push) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
      if (push && !oq_pop) begin
        oq_cnt_r <= oq_cnt_r + 1'b1;
      end else if (oq_pop && !push) begin
        oq_cnt_r <= oq_cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_mem_r[oq_wptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/utf8_cjk_word_splitter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_cjk_word_splitter
// Splits a UTF-8 byte stream into words and ideographs, one byte per result.
// Input channel: write a transaction with in_push while in_full is low; each
// carries one text byte, a byte-valid flag and an end-of-text flag.
// Result channel: while out_empty is low the oldest result is on out_item;
// out_pop takes it. Each result is one word byte with its word number and a
// last-byte mark, or, at end of text, a done transaction with the word count.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0: CJK mode,
// 1: word limit) between texts.
// A decoded character enters the four-deep queue at the edge that accepts its
// last byte. For each character the word sequencer first decides in ST_DECIDE,
// then emits bytes into the result queue, and pops the character when done. The
// last character of a word is held back; its bytes are emitted once the next
// character has been decided, and a done transaction follows its end
// transaction through states ST_CLOSE and ST_DONE.
// Reset clears all text state, sets CJK mode off and the word limit to 65535.
// When the receiver stalls, the two-entry result queue fills, the sequencer
// waits, the character queue fills and in_full rises; nothing is lost.
// ----------------------------------------------------------------------------
module utf8_cjk_word_splitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  ucws_pkg::in_item_t                  in_item,
  output logic                                out_empty,
  input  logic                                out_pop,
  output ucws_pkg::out_item_t                 out_item,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ucws_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import ucws_pkg::*;

  logic        cjk_mode_r;
  logic [15:0] word_limit_r;
  logic        in_acc;
  logic        ev_push, ev_pop, ev_full, ev_empty;
  char_ev_t    ev_data, ev_head;

  assign in_full = ev_full;
  assign in_acc  = in_push && !ev_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cjk_mode_r   <= 1'b0;
      word_limit_r <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CJK_MODE:  cjk_mode_r   <= cfg_wdata[0];
        CFG_MAX_WORDS: word_limit_r <= cfg_wdata[15:0];
        default:       cjk_mode_r   <= cjk_mode_r;
      endcase
    end
  end

  ucws_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .in_acc  (in_acc),
    .ev_push (ev_push),
    .ev_data (ev_data)
  );

  ucws_evq u_evq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (ev_push),
    .push_data (ev_data),
    .pop       (ev_pop),
    .full      (ev_full),
    .empty     (ev_empty),
    .head      (ev_head)
  );

  ucws_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cjk_mode   (cjk_mode_r),
    .word_limit (word_limit_r),
    .ev_empty   (ev_empty),
    .ev_head    (ev_head),
    .ev_pop     (ev_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_item   (out_item)
  );

endmodule
`default_nettype wire
